// ===== design/vfne_pkg.sv =====
// Package for the visited-filtered neighbor expansion block.
// Field widths, mode codes, visited-word layout and the request/response
// structs shared by the top level and the visited map. No dependencies.
package vfne_pkg;

  localparam int unsigned NodeW = 16;
  localparam int unsigned SlotW = 6;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned EntryW = NodeW + 1;   // present flag over neighbor id

  localparam logic [ModeW-1:0] MODE_WRITE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_EXPAND = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [CfgW-1:0] CFG_DEGREE_RESET = 7'd32;

  // visited map is stored as words of flags
  localparam int unsigned VisWordW = 32;
  localparam int unsigned VisBitW  = 5;

  typedef struct packed {
    logic             tas;   // test-and-set the flag of id
    logic             clr;   // start a clearing sweep
    logic [NodeW-1:0] id;
  } vis_req_t;

  typedef struct packed {
    logic busy;      // clearing sweep in progress
    logic was_set;   // flag value before the last test-and-set
  } vis_rsp_t;

endpackage

// ===== design/vfne_visited.sv =====
// Visited map: one-bit flag per node kept in a word-wide synchronous memory.
// Test-and-set with read-modify-write forwarding, plus a clearing sweep.
// Depends on vfne_pkg.
module vfne_visited #(
  parameter int unsigned NUM_NODES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vfne_pkg::vis_req_t req_i,
  output vfne_pkg::vis_rsp_t rsp_o
);
  import vfne_pkg::*;

  localparam int unsigned Words = (NUM_NODES + VisWordW - 1) / VisWordW;
  localparam int unsigned VisAw = (Words > 1) ? $clog2(Words) : 1;

  logic [VisWordW-1:0] vis_mem [Words];

  logic [VisWordW-1:0] rdata_q;
  logic [VisWordW-1:0] byp_data_q;
  logic                byp_q;
  logic                pend_q;
  logic [VisAw-1:0]    pend_addr_q;
  logic [VisBitW-1:0]  pend_bit_q;
  logic                busy_q;
  logic [VisAw-1:0]    clr_cnt_q;

  logic [VisAw-1:0]    raddr;
  logic [VisBitW-1:0]  rbit;
  logic [VisWordW-1:0] old_word;
  logic [VisWordW-1:0] wdata;

  assign raddr = VisAw'(req_i.id >> VisBitW);
  assign rbit  = req_i.id[VisBitW-1:0];

  // a read that met the write-back of the same word sees the written value
  assign old_word = byp_q ? byp_data_q : rdata_q;
  assign wdata    = old_word | (VisWordW'(1) << pend_bit_q);

  assign rsp_o.busy    = busy_q;
  assign rsp_o.was_set = old_word[pend_bit_q];

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      vis_mem[clr_cnt_q] <= '0;
    end else if (pend_q) begin
      vis_mem[pend_addr_q] <= wdata;
    end
    if (req_i.tas) begin
      rdata_q    <= vis_mem[raddr];
      byp_q      <= pend_q && (pend_addr_q == raddr);
      byp_data_q <= wdata;
      pend_addr_q <= raddr;
      pend_bit_q  <= rbit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      pend_q <= req_i.tas;
      if (req_i.clr) begin
        busy_q    <= 1'b1;
        clr_cnt_q <= '0;
      end else if (busy_q) begin
        if (clr_cnt_q == VisAw'(Words - 1)) begin
          busy_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + VisAw'(1);
      end
    end
  end

endmodule

// ===== design/visited_filtered_neighbor_expand_top.sv =====
// Top level of the visited-filtered neighbor expansion block: handshakes,
// scan sequencer and adjacency memory. Depends on vfne_pkg and vfne_visited.
//
//  channel | signals                                   | dir | transfer when
//  --------+-------------------------------------------+-----+--------------------------
//  in      | mode, node, node_present, slot, neighbor, | in  | in_valid_i & in_ready_o
//          | neighbor_present                          |     |
//  out     | neighbor_id, found, last                  | out | out_valid_o & out_ready_i
//  cfg     | cfg_wdata_i (neighbors_per_node)          | in  | cfg_we_i
//
// Slot write, clear request and unused mode leave the sequencer in its idle state.
// Expand scans the row slot by slot: each slot is one adjacency read, followed
// by one visited test-and-set when its id is in range.
// Clear sweeps the visited memory one word a cycle (NUM_NODES/32 words,
// 2048 at default); the same sweep runs after reset. in_ready_o is low meanwhile.
// Results leave through an output register; the scan holds while a found
// result cannot move into it.
module visited_filtered_neighbor_expand_top #(
  parameter int unsigned NUM_NODES  = 65536,
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vfne_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [vfne_pkg::ModeW-1:0] mode_i,
  input  logic [vfne_pkg::NodeW-1:0] node_i,
  input  logic                       node_present_i,
  input  logic [vfne_pkg::SlotW-1:0] slot_i,
  input  logic [vfne_pkg::NodeW-1:0] neighbor_i,
  input  logic                       neighbor_present_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [vfne_pkg::NodeW-1:0] neighbor_id_o,
  output logic                       found_o,
  output logic                       last_o
);
  import vfne_pkg::*;

  localparam int unsigned AdjDepth = NUM_NODES * MAX_DEGREE;
  localparam int unsigned AdjAw    = (AdjDepth > 1) ? $clog2(AdjDepth) : 1;
  localparam int unsigned CntW     = $clog2(MAX_DEGREE + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADJ  = 2'd1;
  localparam logic [1:0] S_TAS  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [EntryW-1:0] adj_mem [AdjDepth];
  logic [EntryW-1:0] adj_rdata_q;

  logic [1:0]       state_q, state_d;
  logic [CfgW-1:0]  cfg_q;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  idx_nxt;
  logic [CntW-1:0]  n_clamp;
  logic [AdjAw-1:0] adj_ptr_q, adj_ptr_d;
  logic             pend_vld_q, pend_vld_d;
  logic [NodeW-1:0] pend_id_q, pend_id_d;
  logic             out_vld_q;
  logic [NodeW-1:0] out_id_q;
  logic             out_found_q, out_last_q;

  logic             in_xfer;
  logic             can_push;
  logic             push;
  logic [NodeW-1:0] push_id;
  logic             push_found, push_last;
  logic             adj_we, adj_re;
  logic [AdjAw-1:0] adj_waddr, adj_raddr, base_addr;
  logic             node_ok, slot_ok, id_ok;
  vis_req_t         vis_req;
  vis_rsp_t         vis_rsp;

  vfne_visited #(
    .NUM_NODES(NUM_NODES)
  ) u_visited (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (vis_req),
    .rsp_o (vis_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE) && !vis_rsp.busy;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign can_push   = !out_vld_q || out_ready_i;

  assign node_ok   = 32'(node_i) < NUM_NODES;
  assign slot_ok   = 32'(slot_i) < MAX_DEGREE;
  assign id_ok     = 32'(adj_rdata_q[NodeW-1:0]) < NUM_NODES;
  assign base_addr = AdjAw'(32'(node_i) * MAX_DEGREE);
  assign adj_waddr = AdjAw'(32'(node_i) * MAX_DEGREE + 32'(slot_i));
  assign n_clamp   = (32'(cfg_q) > MAX_DEGREE) ? CntW'(MAX_DEGREE) : CntW'(cfg_q);
  assign idx_nxt   = idx_q + CntW'(1);

  assign out_valid_o   = out_vld_q;
  assign neighbor_id_o = out_id_q;
  assign found_o       = out_found_q;
  assign last_o        = out_last_q;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    idx_d      = idx_q;
    adj_ptr_d  = adj_ptr_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    adj_we     = 1'b0;
    adj_re     = 1'b0;
    adj_raddr  = adj_ptr_q + AdjAw'(1);
    vis_req    = '0;
    push       = 1'b0;
    push_id    = '0;
    push_found = 1'b0;
    push_last  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (mode_i)
            MODE_WRITE: begin
              adj_we = node_ok && slot_ok;
            end
            MODE_EXPAND: begin
              pend_vld_d = 1'b0;
              state_d    = S_END;
              if (node_present_i && node_ok) begin
                vis_req.tas = 1'b1;
                vis_req.id  = node_i;
                n_d         = n_clamp;
                idx_d       = '0;
                adj_ptr_d   = base_addr;
                if (n_clamp != '0) begin
                  adj_re    = 1'b1;
                  adj_raddr = base_addr;
                  state_d   = S_ADJ;
                end
              end
            end
            MODE_CLEAR: begin
              vis_req.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADJ: begin
        if (!adj_rdata_q[NodeW]) begin
          state_d = S_END;                 // end marker stops the scan
        end else if (id_ok) begin
          vis_req.tas = 1'b1;
          vis_req.id  = adj_rdata_q[NodeW-1:0];
          state_d     = S_TAS;
        end else if (idx_nxt < n_q) begin  // out-of-range id: skip the slot
          adj_re    = 1'b1;
          adj_ptr_d = adj_ptr_q + AdjAw'(1);
          idx_d     = idx_nxt;
        end else begin
          state_d = S_END;
        end
      end

      S_TAS: begin
        // the held find goes out as not-last once a newer one shows up
        if (vis_rsp.was_set || !pend_vld_q || can_push) begin
          if (!vis_rsp.was_set) begin
            push       = pend_vld_q;
            push_id    = pend_id_q;
            push_found = 1'b1;
            pend_vld_d = 1'b1;
            pend_id_d  = adj_rdata_q[NodeW-1:0];
          end
          if (idx_nxt < n_q) begin
            adj_re    = 1'b1;
            adj_ptr_d = adj_ptr_q + AdjAw'(1);
            idx_d     = idx_nxt;
            state_d   = S_ADJ;
          end else begin
            state_d = S_END;
          end
        end
      end

      S_END: begin
        if (can_push) begin
          push       = 1'b1;
          push_id    = pend_vld_q ? pend_id_q : '0;
          push_found = pend_vld_q;
          push_last  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= {neighbor_present_i, neighbor_present_i ? neighbor_i : '0};
    end
    if (adj_re) begin
      adj_rdata_q <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    idx_q     <= idx_d;
    adj_ptr_q <= adj_ptr_d;
    pend_id_q <= pend_id_d;
    if (push) begin
      out_id_q    <= push_id;
      out_found_q <= push_found;
      out_last_q  <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cfg_q      <= CFG_DEGREE_RESET;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/visited_filtered_neighbor_expand_top_tb.sv =====
// Testbench for visited_filtered_neighbor_expand_top: writes adjacency rows, expands nodes and
// clears the visited map under random idling. Results are checked against a local predictor.
// Depends on vfne_pkg and the top level only.
module visited_filtered_neighbor_expand_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vfne_pkg::*;

  localparam int unsigned NUM_NODES     = 65536;
  localparam int unsigned MAX_DEGREE    = 32;
  localparam int unsigned POOL_SIZE     = 16;
  localparam int unsigned PHASE_ITEMS   = 46;
  localparam int unsigned SETTLE_CYCLES = NUM_NODES / VisWordW + 64;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned HOLD_BACKLOG  = 8;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [NodeW-1:0] node;
    logic             node_present;
    logic [SlotW-1:0] slot;
    logic [NodeW-1:0] neighbor;
    logic             neighbor_present;
  } request_t;

  typedef struct packed {
    logic [NodeW-1:0] id;
    logic             found;
    logic             last;
  } neighbor_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  request_t cur_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NodeW-1:0] neighbor_id;
  logic found;
  logic last;

  // stimulus and expected results
  request_t request_q[$];
  neighbor_result_t neighbor_q[$];

  // predictor state
  bit [EntryW-1:0] adj_ref [int unsigned];
  bit visited_ref [NUM_NODES];
  logic [CfgW-1:0] degree_cfg = CFG_DEGREE_RESET;

  // generation-time view of which row slots are written (value = neighbor present)
  bit row_plan [int unsigned];
  logic [NodeW-1:0] node_pool [POOL_SIZE];

  bit calm = 1'b0;
  int unsigned gap_left;
  int unsigned stall_left;
  bit long_hold_done = 1'b0;
  int unsigned planned_items = 0;
  int unsigned requests_done = 0;
  int unsigned expansions_done = 0;
  int unsigned clears_done = 0;
  int unsigned results_seen = 0;
  int unsigned settings_seen = 0;
  int unsigned err_cnt = 0;

  visited_filtered_neighbor_expand_top #(
    .NUM_NODES (NUM_NODES),
    .MAX_DEGREE(MAX_DEGREE)
  ) DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .mode_i            (cur_req.mode),
    .node_i            (cur_req.node),
    .node_present_i    (cur_req.node_present),
    .slot_i            (cur_req.slot),
    .neighbor_i        (cur_req.neighbor),
    .neighbor_present_i(cur_req.neighbor_present),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .neighbor_id_o     (neighbor_id),
    .found_o           (found),
    .last_o            (last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void predict_request(input request_t r);
    int unsigned n;
    int unsigned key;
    bit [EntryW-1:0] entry;
    logic [NodeW-1:0] hits[$];
    case (r.mode)
      MODE_WRITE: begin
        if (r.slot < MAX_DEGREE) begin
          key = int'(r.node) * MAX_DEGREE + int'(r.slot);
          adj_ref[key] = r.neighbor_present ? {1'b1, r.neighbor} : '0;
        end
      end
      MODE_CLEAR: begin
        foreach (visited_ref[i]) visited_ref[i] = 1'b0;
        clears_done++;
      end
      MODE_EXPAND: begin
        expansions_done++;
        if (r.node_present) begin
          n = (degree_cfg > MAX_DEGREE) ? MAX_DEGREE : int'(degree_cfg);
          visited_ref[r.node] = 1'b1;
          for (int i = 0; i < n; i++) begin
            key = int'(r.node) * MAX_DEGREE + i;
            if (!adj_ref.exists(key)) break;
            entry = adj_ref[key];
            if (!entry[NodeW]) break;
            if (!visited_ref[entry[NodeW-1:0]]) begin
              visited_ref[entry[NodeW-1:0]] = 1'b1;
              hits.insert(hits.size(), entry[NodeW-1:0]);
            end
          end
        end
        if (hits.size() == 0) begin
          neighbor_q.insert(neighbor_q.size(),
                            neighbor_result_t'{id: '0, found: 1'b0, last: 1'b1});
        end else begin
          foreach (hits[i])
            neighbor_q.insert(neighbor_q.size(),
                              neighbor_result_t'{id: hits[i], found: 1'b1,
                                                 last: (i == hits.size() - 1)});
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- idling
  function automatic int unsigned draw_idle();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(cur_req);
        requests_done++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req  <= request_q.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string what, input logic [NodeW-1:0] want,
                             input logic [NodeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    neighbor_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (neighbor_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got id %0d found %0b last %0b",
                   $time, neighbor_id, found, last);
          err_cnt++;
        end else begin
          want = neighbor_q.pop_front();
          check_field("neighbor_id", want.id, neighbor_id);
          check_field("found", NodeW'(want.found), NodeW'(found));
          check_field("last", NodeW'(want.last), NodeW'(last));
        end
        // one long hold-off so the block backs up into its input
        if (!long_hold_done && request_q.size() > HOLD_BACKLOG) begin
          long_hold_done = 1'b1;
          stall_left = LONG_HOLD;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = draw_idle();
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic bit scan_reads_written(input logic [NodeW-1:0] nd);
    int unsigned n;
    int unsigned key;
    n = (degree_cfg > MAX_DEGREE) ? MAX_DEGREE : int'(degree_cfg);
    for (int i = 0; i < n; i++) begin
      key = int'(nd) * MAX_DEGREE + i;
      if (!row_plan.exists(key)) return 1'b0;
      if (!row_plan[key]) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [NodeW-1:0] pick_neighbor();
    if ($urandom_range(0, 4) != 0) return node_pool[$urandom_range(0, POOL_SIZE - 1)];
    return NodeW'($urandom);
  endfunction

  task automatic queue_request(input logic [ModeW-1:0] mode, input logic [NodeW-1:0] nd,
                               input logic np, input logic [SlotW-1:0] slot,
                               input logic [NodeW-1:0] nb, input logic nbp);
    request_q.insert(request_q.size(),
                     request_t'{mode: mode, node: nd, node_present: np, slot: slot,
                                neighbor: nb, neighbor_present: nbp});
    if (mode == MODE_WRITE && slot < MAX_DEGREE)
      row_plan[int'(nd) * MAX_DEGREE + int'(slot)] = nbp;
    if (mode != MODE_UNUSED && !(mode == MODE_WRITE && slot >= MAX_DEGREE))
      planned_items++;
  endtask

  // well-formed row: len neighbors, then an end marker unless the row is full
  task automatic queue_row(input logic [NodeW-1:0] nd, input int unsigned len);
    for (int i = 0; i < len; i++)
      queue_request(MODE_WRITE, nd, 1'($urandom), SlotW'(i), pick_neighbor(), 1'b1);
    if (len < MAX_DEGREE)
      queue_request(MODE_WRITE, nd, 1'($urandom), SlotW'(len), NodeW'($urandom), 1'b0);
  endtask

  task automatic queue_expand(input logic [NodeW-1:0] nd);
    if (!scan_reads_written(nd)) queue_row(nd, $urandom_range(0, MAX_DEGREE));
    queue_request(MODE_EXPAND, nd, 1'b1, SlotW'($urandom), NodeW'($urandom), 1'($urandom));
  endtask

  task automatic run_random_phase(input int unsigned target);
    int unsigned base;
    int unsigned pick;
    logic [NodeW-1:0] nd;
    logic [SlotW-1:0] slot;
    base = planned_items;
    while (planned_items - base < target) begin
      pick = $urandom_range(0, 99);
      nd = node_pool[$urandom_range(0, POOL_SIZE - 1)];
      slot = ($urandom_range(0, 9) == 0) ? SlotW'($urandom_range(MAX_DEGREE, 63))
                                         : SlotW'($urandom_range(0, MAX_DEGREE - 1));
      if (pick < 45)
        queue_expand(nd);
      else if (pick < 55)
        queue_request(MODE_EXPAND, NodeW'($urandom), 1'b0, SlotW'($urandom),
                      NodeW'($urandom), 1'($urandom));
      else if (pick < 77)
        queue_request(MODE_WRITE, nd, 1'($urandom), slot, pick_neighbor(),
                      $urandom_range(0, 5) != 0);
      else if (pick < 87)
        queue_row(nd, $urandom_range(0, MAX_DEGREE));
      else if (pick < 91)
        queue_expand(NodeW'($urandom));
      else if (pick < 96)
        queue_request(MODE_CLEAR, NodeW'($urandom), 1'($urandom), SlotW'($urandom),
                      NodeW'($urandom), 1'($urandom));
      else
        queue_request(MODE_UNUSED, NodeW'($urandom), 1'($urandom), SlotW'($urandom),
                      NodeW'($urandom), 1'($urandom));
    end
  endtask

  // nothing pending, nothing expected, then room for a clearing sweep to finish
  task automatic wait_idle();
    do @(posedge clk);
    while (request_q.size() != 0 || in_valid || neighbor_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_degree(input logic [CfgW-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    degree_cfg = value;
    settings_seen++;
  endtask

  initial begin
    node_pool[0] = '0;
    node_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) node_pool[i] = NodeW'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset degree
    calm = 1'b1;
    queue_request(MODE_EXPAND, 16'h0000, 1'b0, '0, 16'h0000, 1'b0);  // absent node
    queue_request(MODE_EXPAND, 16'hFFFF, 1'b0, '1, 16'hFFFF, 1'b1);
    queue_request(MODE_WRITE, 16'h0000, 1'b0, 6'd0, 16'hFFFF, 1'b1);
    queue_request(MODE_WRITE, 16'h0000, 1'b1, 6'd1, 16'h0001, 1'b1);
    queue_request(MODE_WRITE, 16'h0000, 1'b0, 6'd2, 16'hFFFF, 1'b1);  // duplicate in row
    queue_request(MODE_WRITE, 16'h0000, 1'b1, 6'd3, 16'hA5A5, 1'b0);  // end marker
    queue_request(MODE_WRITE, 16'h0000, 1'b1, 6'd63, 16'h1234, 1'b1); // slot past row
    queue_request(MODE_WRITE, 16'h0000, 1'b0, 6'd32, 16'h4321, 1'b1);
    queue_request(MODE_UNUSED, 16'hFFFF, 1'b1, '1, 16'hFFFF, 1'b1);
    queue_request(MODE_EXPAND, 16'h0000, 1'b1, '0, 16'h0000, 1'b0);
    queue_request(MODE_EXPAND, 16'h0000, 1'b1, '1, 16'hFFFF, 1'b1);  // all visited now
    queue_request(MODE_WRITE, 16'hFFFF, 1'b1, 6'd0, 16'h0000, 1'b1);
    queue_request(MODE_WRITE, 16'hFFFF, 1'b1, 6'd1, 16'hFFFF, 1'b1);  // self loop
    queue_request(MODE_WRITE, 16'hFFFF, 1'b1, 6'd2, 16'h0000, 1'b0);
    queue_request(MODE_EXPAND, 16'hFFFF, 1'b1, '0, 16'h0000, 1'b0);
    queue_request(MODE_CLEAR, 16'h0000, 1'b0, '0, 16'h0000, 1'b0);
    queue_request(MODE_EXPAND, 16'hFFFF, 1'b1, '0, 16'h0000, 1'b0);  // finds id 0
    queue_request(MODE_EXPAND, 16'h0000, 1'b1, '0, 16'h0000, 1'b0);
    wait_idle();
    calm = 1'b0;

    run_random_phase(PHASE_ITEMS);
    set_degree(7'd5);
    run_random_phase(PHASE_ITEMS);
    set_degree(7'd0);
    run_random_phase(PHASE_ITEMS);

    // register above the built degree, with one full row of fresh neighbors
    set_degree(7'd127);
    queue_request(MODE_CLEAR, '1, 1'b1, '1, '1, 1'b1);
    for (int i = 0; i < MAX_DEGREE; i++)
      queue_request(MODE_WRITE, 16'h7FFF, 1'b1, SlotW'(i), 16'h8000 + NodeW'(i), 1'b1);
    queue_expand(16'h7FFF);
    run_random_phase(PHASE_ITEMS);

    set_degree(7'd1);
    run_random_phase(PHASE_ITEMS);
    set_degree(7'd64);
    calm = 1'b1;
    run_random_phase(PHASE_ITEMS);
    set_degree(7'd32);
    calm = 1'b0;
    run_random_phase(PHASE_ITEMS);
    set_degree(CfgW'($urandom_range(2, MAX_DEGREE - 1)));
    run_random_phase(PHASE_ITEMS);

    wait_idle();
    $display("Ran %0d transfers: %0d expansions, %0d visited-map clears, %0d degree writes.",
             requests_done, expansions_done, clears_done, settings_seen);
    $display("Checked %0d expansion results, %0d mismatches.", results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("visited_filtered_neighbor_expand_top regression: pass");
    end else begin
      $display("visited_filtered_neighbor_expand_top regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still expected.", neighbor_q.size());
    $display("visited_filtered_neighbor_expand_top regression: fail");
    $finish;
  end

endmodule
